### hw/rtl/wpm_pkg.sv
// shared types and constants for the wildcard pattern matcher
package wpm_pkg;

  // pattern capacity and derived widths
  localparam int unsigned MAX_PATTERN = 64;
  localparam int unsigned ROW_W       = MAX_PATTERN + 1;
  localparam int unsigned LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int unsigned ADDR_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned PFX_LVLS    = $clog2(ROW_W);

  // special pattern bytes
  localparam logic [7:0] STAR_BYTE     = 8'h2A;
  localparam logic [7:0] QUESTION_BYTE = 8'h3F;

  // item operations
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } op_e;

  // classified item as it travels through the queue
  typedef struct packed {
    op_e        op;
    logic [7:0] sym;
    logic       sym_star;
    logic       sym_question;
  } cmd_t;

endpackage

### hw/rtl/wpm_front.sv
// front end: accepts items, classifies them and queues them for the row engine
module wpm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    in_opcode_i,
  input  logic [7:0]    in_symbol_i,
  output logic          cmd_valid_o,
  output wpm_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);

  logic [1:0]    count_q, count_d;
  logic          wr_ptr_q, rd_ptr_q;
  wpm_pkg::cmd_t entry_q [2];
  wpm_pkg::cmd_t cmd_new;
  logic          push;

  // classify the incoming item
  always_comb begin
    cmd_new.op           = wpm_pkg::op_e'(in_opcode_i);
    cmd_new.sym          = in_symbol_i;
    cmd_new.sym_star     = (in_symbol_i == wpm_pkg::STAR_BYTE);
    cmd_new.sym_question = (in_symbol_i == wpm_pkg::QUESTION_BYTE);
  end

  // two-entry queue handshake
  assign in_stall_o  = (count_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !cmd_pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && cmd_pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  // queue pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

### hw/rtl/wpm_back.sv
// back end: pattern cells, bit-parallel match row update and result register
module wpm_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  wpm_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          out_matched_o,
  output logic          out_overflow_o
);

  localparam int unsigned ROW_W    = wpm_pkg::ROW_W;
  localparam int unsigned LVLS     = wpm_pkg::PFX_LVLS;
  localparam int unsigned MAXP     = wpm_pkg::MAX_PATTERN;
  localparam int unsigned LEN_W    = wpm_pkg::LEN_W;
  localparam int unsigned ADDR_W   = wpm_pkg::ADDR_W;

  // pattern cells, one per position
  logic [7:0]        pat_byte_q [MAXP];
  logic [MAXP-1:0]   pat_star_q;
  logic [MAXP-1:0]   pat_quest_q;

  // row state
  logic [LEN_W-1:0]  len_q, len_d;
  logic [ROW_W-1:0]  len_mask_q, len_mask_d;
  logic [ROW_W-1:0]  start_row_q, start_row_d;
  logic [ROW_W-1:0]  match_q, match_d;
  logic [ROW_W-1:0]  col_q, col_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q;
  logic              out_matched_q, out_overflow_q;

  // text update intermediates
  logic [ROW_W-1:0]          hit;
  logic [ROW_W-1:0]          star_pos;
  logic [LVLS:0][ROW_W-1:0]  gen_lv;
  logic [LVLS:0][ROW_W-1:0]  prp_lv;
  logic [ROW_W-1:0]          col_text;
  logic [ROW_W-1:0]          match_text;

  logic pop;
  logic room;
  logic do_write;

  // pop unless an end item finds the result register blocked
  assign room      = !out_valid_q || !out_stall_i;
  assign pop       = cmd_valid_i && ((cmd_i.op != wpm_pkg::OP_END) || room);
  assign cmd_pop_o = pop;
  assign do_write  = pop && (cmd_i.op == wpm_pkg::OP_APPEND) && (len_q < LEN_W'(MAXP));

  // per-position hits and star propagation flags
  always_comb begin
    hit      = '0;
    star_pos = '0;
    for (int j = 1; j < ROW_W; j++) begin
      star_pos[j] = len_mask_q[j] & pat_star_q[j-1];
      if (pat_quest_q[j-1]) begin
        hit[j] = len_mask_q[j] & match_q[j-1];
      end else begin
        hit[j] = len_mask_q[j] & ~pat_star_q[j-1] &
                 (pat_byte_q[j-1] == cmd_i.sym) & match_q[j-1];
      end
    end
  end

  // column or-chain across star runs as a parallel prefix
  always_comb begin
    gen_lv[0]    = col_q | hit;
    gen_lv[0][0] = 1'b1;
    prp_lv[0]    = star_pos;
    for (int lvl = 0; lvl < LVLS; lvl++) begin
      for (int j = 0; j < ROW_W; j++) begin
        if (j >= (1 << lvl)) begin
          gen_lv[lvl+1][j] = gen_lv[lvl][j] | (prp_lv[lvl][j] & gen_lv[lvl][j - (1 << lvl)]);
          prp_lv[lvl+1][j] = prp_lv[lvl][j] & prp_lv[lvl][j - (1 << lvl)];
        end else begin
          gen_lv[lvl+1][j] = gen_lv[lvl][j];
          prp_lv[lvl+1][j] = prp_lv[lvl][j];
        end
      end
    end
    col_text   = gen_lv[LVLS];
    match_text = '0;
    for (int j = 1; j < ROW_W; j++) begin
      match_text[j] = star_pos[j] ? col_text[j-1] : hit[j];
    end
  end

  // next row state per operation
  always_comb begin
    len_d       = len_q;
    len_mask_d  = len_mask_q;
    start_row_d = start_row_q;
    match_d     = match_q;
    col_d       = col_q;
    ovf_d       = ovf_q;
    if (pop) begin
      case (cmd_i.op)
        wpm_pkg::OP_CLEAR: begin
          len_d       = '0;
          len_mask_d  = ROW_W'(1);
          start_row_d = ROW_W'(1);
          ovf_d       = 1'b0;
          match_d     = ROW_W'(1);
          col_d       = ROW_W'(1);
        end
        wpm_pkg::OP_APPEND: begin
          if (do_write) begin
            len_d                             = len_q + LEN_W'(1);
            len_mask_d[len_q + LEN_W'(1)]     = 1'b1;
            start_row_d[len_q + LEN_W'(1)]    = start_row_q[len_q] & cmd_i.sym_star;
            match_d                           = start_row_d;
            col_d                             = start_row_d;
          end else begin
            ovf_d   = 1'b1;
            match_d = start_row_q;
            col_d   = start_row_q;
          end
        end
        wpm_pkg::OP_TEXT: begin
          match_d = match_text;
          col_d   = col_text;
        end
        wpm_pkg::OP_END: begin
          match_d = start_row_q;
          col_d   = start_row_q;
        end
        default: begin
          match_d = match_q;
        end
      endcase
    end
  end

  // row control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      len_mask_q  <= ROW_W'(1);
      start_row_q <= ROW_W'(1);
      match_q     <= ROW_W'(1);
      col_q       <= ROW_W'(1);
      ovf_q       <= 1'b0;
    end else begin
      len_q       <= len_d;
      len_mask_q  <= len_mask_d;
      start_row_q <= start_row_d;
      match_q     <= match_d;
      col_q       <= col_d;
      ovf_q       <= ovf_d;
    end
  end

  // pattern cell writes
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      pat_byte_q[len_q[ADDR_W-1:0]]  <= cmd_i.sym;
      pat_star_q[len_q[ADDR_W-1:0]]  <= cmd_i.sym_star;
      pat_quest_q[len_q[ADDR_W-1:0]] <= cmd_i.sym_question;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop && (cmd_i.op == wpm_pkg::OP_END)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (pop && (cmd_i.op == wpm_pkg::OP_END)) begin
      out_matched_q  <= match_q[len_q];
      out_overflow_q <= ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_matched_o  = out_matched_q;
  assign out_overflow_o = out_overflow_q;

  // a column bit is set wherever its match bit is set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (match_q & ~col_q) == '0)
    else $error("match row bit set without column bit");

  // rows stay empty past the pattern length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((match_q | col_q | start_row_q) & ~len_mask_q) == '0)
    else $error("row bit set beyond pattern length");

  // empty prefix column is always seen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q[0] && start_row_q[0] && len_mask_q[0])
    else $error("position zero lost");

  // a blocked end item never leaves the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && (cmd_i.op == wpm_pkg::OP_END) && out_valid_q && out_stall_i) |-> !cmd_pop_o)
    else $error("end item popped while result register blocked");

endmodule

### hw/rtl/wildcard_pattern_match.sv
// wildcard pattern matcher: whole-text match against a stored '*' / '?' pattern
// out_valid_o is registered: an end item passes the queue, then the row engine pops it into the result register
// throughput: one item per cycle while the queue has room, set by the bit-parallel row update;
// an end item waits in the two-entry queue while an unread result is held
// reset: empty pattern, overflow clear, rows at start value, queue and result empty
// pattern cells are not reset; only positions below the current length are used
module wildcard_pattern_match (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] in_opcode_i,
  input  logic [7:0] in_symbol_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       out_matched_o,
  output logic       out_overflow_o
);

  logic          cmd_valid;
  logic          cmd_pop;
  wpm_pkg::cmd_t cmd;

  // item intake and queue
  wpm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_opcode_i (in_opcode_i),
    .in_symbol_i (in_symbol_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // row engine and result register
  wpm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_matched_o  (out_matched_o),
    .out_overflow_o (out_overflow_o)
  );

endmodule

### dv/wildcard_pattern_match_test.sv
// testbench for the wildcard pattern matcher: directed table, random sequences, scoreboard
`timescale 1ns / 100ps

module wildcard_pattern_match_test;

  // one match verdict as carried by a result item
  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  // one row of the directed table; reps repeats the item, fixed rows carry a typed verdict
  typedef struct {
    wpm_pkg::op_e op;
    logic [7:0]   sym;
    int           reps;
    bit           fixed;
    logic         want_matched;
    logic         want_overflow;
  } stim_row_t;

  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned PHASE_ITEMS  = 150;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] in_opcode_i;
  logic [7:0] in_symbol_i;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       out_matched_o;
  logic       out_overflow_o;

  wildcard_pattern_match DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_opcode_i    (in_opcode_i),
    .in_symbol_i    (in_symbol_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_matched_o  (out_matched_o),
    .out_overflow_o (out_overflow_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // matcher state kept by the testbench
  logic [7:0]     pattern_bytes [wpm_pkg::MAX_PATTERN];
  int unsigned    pattern_len;
  logic [wpm_pkg::ROW_W-1:0] prefix_hits;
  logic [wpm_pkg::ROW_W-1:0] prefix_reached;
  logic           appends_dropped;

  verdict_t    pending_verdicts [$];
  logic [7:0]  pattern_draft [$];
  logic [7:0]  text_draft [$];
  int unsigned items_sent;
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned error_count;
  int unsigned verdicts_seen;
  int unsigned matches_seen;
  int unsigned overflows_seen;

  // directed items: corner cases first, overflow and clear at the end
  stim_row_t directed_rows [24] = '{
    '{wpm_pkg::OP_END,    8'h00,                  1,  1'b1, 1'b1, 1'b0}, // empty text, pattern
    '{wpm_pkg::OP_TEXT,   8'h00,                  1,  1'b0, 1'b0, 1'b0},
    '{wpm_pkg::OP_END,    8'hFF,                  1,  1'b1, 1'b0, 1'b0}, // text on empty pattern
    '{wpm_pkg::OP_APPEND, wpm_pkg::STAR_BYTE,     1,  1'b0, 1'b0, 1'b0},
    '{wpm_pkg::OP_END,    8'h00,                  1,  1'b1, 1'b1, 1'b0}, // empty text, all star
    '{wpm_pkg::OP_APPEND, wpm_pkg::QUESTION_BYTE, 1,  1'b0, 1'b0, 1'b0},
    '{wpm_pkg::OP_TEXT,   8'hFF,                  1,  1'b0, 1'b0, 1'b0},
    '{wpm_pkg::OP_TEXT,   8'h00,                  1,  1'b0, 1'b0, 1'b0},
    '{wpm_pkg::OP_END,    8'h00,                  1,  1'b0, 1'b0, 1'b0},
    '{wpm_pkg::OP_APPEND, 8'hFF,                  1,  1'b0, 1'b0, 1'b0},
    '{wpm_pkg::OP_TEXT,   8'h00,                  1,  1'b0, 1'b0, 1'b0},
    '{wpm_pkg::OP_TEXT,   8'h00,                  1,  1'b0, 1'b0, 1'b0},
    '{wpm_pkg::OP_TEXT,   8'hFF,                  1,  1'b0, 1'b0, 1'b0},
    '{wpm_pkg::OP_END,    8'hFF,                  1,  1'b0, 1'b0, 1'b0},
    '{wpm_pkg::OP_END,    8'h00,                  1,  1'b1, 1'b0, 1'b0}, // empty text, non-star
    '{wpm_pkg::OP_CLEAR,  8'hFF,                  1,  1'b0, 1'b0, 1'b0},
    '{wpm_pkg::OP_APPEND, 8'h00,                  1,  1'b0, 1'b0, 1'b0},
    '{wpm_pkg::OP_TEXT,   8'h00,                  1,  1'b0, 1'b0, 1'b0},
    '{wpm_pkg::OP_END,    8'h00,                  1,  1'b0, 1'b0, 1'b0},
    '{wpm_pkg::OP_APPEND, wpm_pkg::STAR_BYTE,     70, 1'b0, 1'b0, 1'b0}, // runs past capacity
    '{wpm_pkg::OP_TEXT,   8'h00,                  1,  1'b0, 1'b0, 1'b0},
    '{wpm_pkg::OP_END,    8'hFF,                  1,  1'b0, 1'b0, 1'b0},
    '{wpm_pkg::OP_CLEAR,  8'h00,                  1,  1'b0, 1'b0, 1'b0},
    '{wpm_pkg::OP_END,    8'hFF,                  1,  1'b1, 1'b1, 1'b0}  // clear drops overflow
  };

  // rows back to start value: a prefix is live while the pattern so far is all star
  function void rewind_prefixes();
    logic lead;
    lead = 1'b1;
    prefix_hits       = '0;
    prefix_reached    = '0;
    prefix_hits[0]    = 1'b1;
    prefix_reached[0] = 1'b1;
    for (int j = 1; j <= pattern_len; j++) begin
      if (pattern_bytes[j-1] != wpm_pkg::STAR_BYTE) lead = 1'b0;
      prefix_hits[j]    = lead;
      prefix_reached[j] = lead;
    end
  endfunction

  // one text byte through the row; star takes the column-or of the prefix one shorter
  function void advance_prefixes(input logic [7:0] text_byte);
    logic       diag;
    logic       held;
    logic       hit;
    logic [7:0] pat;
    diag = prefix_hits[0];
    prefix_hits[0]    = 1'b0;
    prefix_reached[0] = 1'b1;
    for (int j = 1; j <= pattern_len; j++) begin
      held = prefix_hits[j];
      pat  = pattern_bytes[j-1];
      if (pat == wpm_pkg::STAR_BYTE) hit = prefix_reached[j-1];
      else if (pat == wpm_pkg::QUESTION_BYTE) hit = diag;
      else hit = (pat == text_byte) && diag;
      prefix_hits[j]    = hit;
      prefix_reached[j] = prefix_reached[j] | hit;
      diag = held;
    end
  endfunction

  // apply one accepted item; returns 1 when it yields a verdict
  function bit predict_verdict(input wpm_pkg::op_e op, input logic [7:0] sym,
                               output verdict_t v);
    v = '0;
    case (op)
      wpm_pkg::OP_CLEAR: begin
        pattern_len     = 0;
        appends_dropped = 1'b0;
        rewind_prefixes();
        return 1'b0;
      end
      wpm_pkg::OP_APPEND: begin
        if (pattern_len < wpm_pkg::MAX_PATTERN) begin
          pattern_bytes[pattern_len] = sym;
          pattern_len++;
        end else begin
          appends_dropped = 1'b1;
        end
        rewind_prefixes();
        return 1'b0;
      end
      wpm_pkg::OP_TEXT: begin
        advance_prefixes(sym);
        return 1'b0;
      end
      default: begin
        v.matched  = prefix_hits[pattern_len];
        v.overflow = appends_dropped;
        rewind_prefixes();
        return 1'b1;
      end
    endcase
  endfunction

  // drive one item, wait for acceptance, then record what it should yield
  task send_item(input wpm_pkg::op_e op, input logic [7:0] sym, input bit fixed = 1'b0,
                 input verdict_t typed = '0);
    verdict_t v;
    case ((items_sent / PHASE_ITEMS) % 4)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 46; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 46; end
      default: begin in_idle_pct = 19; out_stall_pct = 19; end
    endcase
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_opcode_i <= op;
    in_symbol_i <= sym;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    items_sent++;
    if (predict_verdict(op, sym, v)) pending_verdicts.push_back(fixed ? typed : v);
  endtask

  // hold the sender off until every pending verdict has come back
  task drain_verdicts();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_verdicts.size() != 0);
  endtask

  // text bytes lean on a two-letter alphabet so patterns hit often
  function logic [7:0] pick_text_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return 8'h61;
    if (r < 80) return 8'h62;
    return 8'($urandom_range(255));
  endfunction

  function logic [7:0] pick_pattern_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return wpm_pkg::STAR_BYTE;
    if (r < 50) return wpm_pkg::QUESTION_BYTE;
    if (r < 90) return ($urandom_range(1) != 0) ? 8'h61 : 8'h62;
    return 8'($urandom_range(255));
  endfunction

  // text built to fit the stored pattern, sometimes spoiled afterwards; random text otherwise
  function void build_text(input bit aim_match);
    int unsigned n;
    text_draft.delete();
    if (aim_match) begin
      foreach (pattern_draft[k]) begin
        if (k >= wpm_pkg::MAX_PATTERN) break;
        if (pattern_draft[k] == wpm_pkg::STAR_BYTE) begin
          n = $urandom_range(3);
          repeat (n) text_draft.push_back(pick_text_byte());
        end else if (pattern_draft[k] == wpm_pkg::QUESTION_BYTE) begin
          text_draft.push_back(pick_text_byte());
        end else begin
          text_draft.push_back(pattern_draft[k]);
        end
      end
      if ($urandom_range(4) == 0 && text_draft.size() != 0) begin
        if ($urandom_range(1) != 0) text_draft[$urandom_range(text_draft.size() - 1)] =
            pick_text_byte();
        else void'(text_draft.pop_back());
      end
    end else begin
      n = $urandom_range(10);
      repeat (n) text_draft.push_back(pick_text_byte());
    end
  endfunction

  // one random sequence: mostly clear, pattern, several texts; otherwise raw noise
  task run_sequence();
    int unsigned plen;
    int unsigned texts;
    if ($urandom_range(99) < 85) begin
      send_item(wpm_pkg::OP_CLEAR, 8'($urandom_range(255)));
      plen = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(8);
      pattern_draft.delete();
      repeat (plen) pattern_draft.push_back(pick_pattern_byte());
      foreach (pattern_draft[k]) send_item(wpm_pkg::OP_APPEND, pattern_draft[k]);
      texts = $urandom_range(1, 4);
      repeat (texts) begin
        build_text($urandom_range(99) < 60);
        foreach (text_draft[k]) send_item(wpm_pkg::OP_TEXT, text_draft[k]);
        send_item(wpm_pkg::OP_END, 8'($urandom_range(255)));
      end
    end else begin
      repeat ($urandom_range(1, 6))
        send_item(wpm_pkg::op_e'($urandom_range(3)), 8'($urandom_range(255)));
    end
  endtask

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // compare each accepted result with the oldest pending verdict
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result: matched %0b overflow %0b", out_matched_o, out_overflow_o);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        verdicts_seen++;
        if (out_matched_o === 1'b1) matches_seen++;
        if (out_overflow_o === 1'b1) overflows_seen++;
        if (out_matched_o !== want.matched) begin
          $error("matched: expected %0b, actual %0b", want.matched, out_matched_o);
          error_count++;
        end
        if (out_overflow_o !== want.overflow) begin
          $error("overflow: expected %0b, actual %0b", want.overflow, out_overflow_o);
          error_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    verdict_t typed;
    bit       paused;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_opcode_i <= wpm_pkg::OP_CLEAR;
    in_symbol_i <= 8'h00;
    items_sent     = 0;
    in_idle_pct    = 0;
    out_stall_pct  = 0;
    error_count    = 0;
    verdicts_seen  = 0;
    matches_seen   = 0;
    overflows_seen = 0;
    paused         = 1'b0;
    pattern_len     = 0;
    appends_dropped = 1'b0;
    rewind_prefixes();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[i]) begin
      typed.matched  = directed_rows[i].want_matched;
      typed.overflow = directed_rows[i].want_overflow;
      repeat (directed_rows[i].reps)
        send_item(directed_rows[i].op, directed_rows[i].sym, directed_rows[i].fixed, typed);
    end

    // random sequences, with one full drain halfway through
    while (items_sent < RANDOM_ITEMS) begin
      run_sequence();
      if (!paused && items_sent > RANDOM_ITEMS / 2) begin
        drain_verdicts();
        paused = 1'b1;
      end
    end

    // let the pipeline empty, then keep watching for strays
    drain_verdicts();
    repeat (8) @(posedge clk_i);

    $display("%0d items sent, %0d verdicts checked (%0d matched, %0d with overflow)",
             items_sent, verdicts_seen, matches_seen, overflows_seen);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/wpm_pkg.sv
hw/rtl/wpm_front.sv
hw/rtl/wpm_back.sv
hw/rtl/wildcard_pattern_match.sv
dv/wildcard_pattern_match_test.sv
